@@ rtl/core/i2cmbs_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cmbs_pkg: shared types and constants for the I2C master bit sequencer
// Operation codes, sequence widths and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbs_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned BITS_W  = 4;
  localparam int unsigned POLL_W  = 8;

  localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'd250;
  localparam logic [BITS_W-1:0] LAST_BIT      = 4'd7;

  // Operation codes; stop-with-error exists only as an internal sequence
  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_WRITE    = 3'd3,
    OP_WAIT     = 3'd4,
    OP_READ     = 3'd5,
    OP_STOP_ERR = 3'd6
  } op_e_t;

  // Sequence phases (values of the phase counter)
  localparam logic [PHASE_W-1:0] PH_0 = 3'd0;
  localparam logic [PHASE_W-1:0] PH_1 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_2 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_3 = 3'd3;
  localparam logic [PHASE_W-1:0] PH_4 = 3'd4;

  // One result transfer
  typedef struct packed {
    logic              scl;
    logic              sda_out;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic              ack_error;
    logic [BYTE_W-1:0] read_data;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/i2c_master_bit_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit: I2C master line sequencer
// Loads start, stop, write, acknowledge-wait and read sequences and applies
// one SCL/SDA pin update per tick, sending and receiving MSB first.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid / in_stall  operation, data_byte, sda_level
//  out_     output     out_valid/out_stall  scl, sda_out, sda_drive, busy_res,
//                                           done_res, ack_error, read_data
//  cfg_     input      cfg_wr_en            cfg_wr_data (ack_timeout)
//
//  One item per clock while in_stall is low: each accepted transfer updates
//  the sequencer state, and its result is registered in out_r or skid_r.
//  The output register plus a one-entry skid buffer let input keep flowing
//  while a result waits; in_stall rises only when both hold results.
//  Synchronous active-low reset idles the sequencer, drives both lines high
//  and restores ack_timeout to 250.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_wr_en,
  input  wire logic [i2cmbs_pkg::BYTE_W-1:0] cfg_wr_data,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [i2cmbs_pkg::OP_W-1:0]   in_operation,
  input  wire logic [i2cmbs_pkg::BYTE_W-1:0] in_data_byte,
  input  wire logic                         in_sda_level,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_scl,
  output logic                              out_sda_out,
  output logic                              out_sda_drive,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic                              out_ack_error,
  output logic [i2cmbs_pkg::BYTE_W-1:0]      out_read_data
);

  // Sequencer state
  logic [i2cmbs_pkg::BYTE_W-1:0]  timeout_r;
  i2cmbs_pkg::op_e_t              active_op_r, active_op_nxt;
  logic [i2cmbs_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [i2cmbs_pkg::BITS_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [i2cmbs_pkg::BYTE_W-1:0]  shift_r, shift_nxt;
  logic [i2cmbs_pkg::POLL_W-1:0]  poll_r, poll_nxt;
  logic                           scl_r, scl_nxt;
  logic                           sda_r, sda_nxt;
  logic                           drive_r, drive_nxt;

  // Output register and skid buffer
  i2cmbs_pkg::res_t out_r, skid_r, res_nxt;
  logic             out_vld_r, skid_vld_r;

  logic             in_xfer, out_xfer;
  logic [i2cmbs_pkg::POLL_W:0] poll_inc;
  logic             done, err;
  logic [i2cmbs_pkg::BYTE_W-1:0] rdata;
  logic             is_cmd;

  assign in_stall = skid_vld_r;
  assign in_xfer  = in_valid & ~skid_vld_r;
  assign out_xfer = out_vld_r & ~out_stall;

  assign is_cmd   = (in_operation >= i2cmbs_pkg::OP_START) &&
                    (in_operation <= i2cmbs_pkg::OP_READ);
  assign poll_inc = {1'b0, poll_r} + {{i2cmbs_pkg::POLL_W{1'b0}}, 1'b1};

  // Step the active sequence for one transfer
  always_comb begin
    active_op_nxt = active_op_r;
    phase_nxt     = phase_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    poll_nxt      = poll_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    drive_nxt     = drive_r;
    done          = 1'b0;
    err           = 1'b0;
    rdata         = '0;

    if (active_op_r == i2cmbs_pkg::OP_TICK) begin
      // load a command while idle
      if (is_cmd) begin
        active_op_nxt = i2cmbs_pkg::op_e_t'(in_operation);
        phase_nxt     = i2cmbs_pkg::PH_0;
        bit_cnt_nxt   = '0;
        poll_nxt      = '0;
        shift_nxt     = (in_operation == i2cmbs_pkg::OP_WRITE) ? in_data_byte : '0;
      end
    end else if (in_operation == i2cmbs_pkg::OP_TICK) begin
      unique case (active_op_r)
        i2cmbs_pkg::OP_START: begin
          unique case (phase_r)
            i2cmbs_pkg::PH_0: begin
              drive_nxt = 1'b1;
              sda_nxt   = 1'b1;
            end
            i2cmbs_pkg::PH_1: scl_nxt = 1'b1;
            i2cmbs_pkg::PH_2: sda_nxt = 1'b0;
            default: begin
              scl_nxt = 1'b0;
              done    = 1'b1;
            end
          endcase
          phase_nxt = phase_r + 1'b1;
        end
        i2cmbs_pkg::OP_STOP, i2cmbs_pkg::OP_STOP_ERR: begin
          unique case (phase_r)
            i2cmbs_pkg::PH_0: scl_nxt = 1'b0;
            i2cmbs_pkg::PH_1: begin
              drive_nxt = 1'b1;
              sda_nxt   = 1'b0;
            end
            i2cmbs_pkg::PH_2: scl_nxt = 1'b1;
            default: begin
              sda_nxt = 1'b1;
              done    = 1'b1;
              err     = (active_op_r == i2cmbs_pkg::OP_STOP_ERR);
            end
          endcase
          phase_nxt = phase_r + 1'b1;
        end
        i2cmbs_pkg::OP_WRITE: begin
          unique case (phase_r)
            i2cmbs_pkg::PH_0: begin
              drive_nxt = 1'b1;
              scl_nxt   = 1'b0;
              phase_nxt = i2cmbs_pkg::PH_1;
            end
            i2cmbs_pkg::PH_1: begin
              sda_nxt   = shift_r[i2cmbs_pkg::BYTE_W-1];
              phase_nxt = i2cmbs_pkg::PH_2;
            end
            i2cmbs_pkg::PH_2: begin
              scl_nxt   = 1'b1;
              phase_nxt = i2cmbs_pkg::PH_3;
            end
            default: begin
              scl_nxt     = 1'b0;
              shift_nxt   = {shift_r[i2cmbs_pkg::BYTE_W-2:0], 1'b0};
              bit_cnt_nxt = bit_cnt_r + 1'b1;
              phase_nxt   = i2cmbs_pkg::PH_0;
              done        = (bit_cnt_r >= i2cmbs_pkg::LAST_BIT);
            end
          endcase
        end
        i2cmbs_pkg::OP_WAIT: begin
          if (phase_r == i2cmbs_pkg::PH_0) begin
            // release SDA and raise SCL
            drive_nxt = 1'b0;
            scl_nxt   = 1'b1;
            poll_nxt  = '0;
            phase_nxt = i2cmbs_pkg::PH_1;
          end else if (!in_sda_level) begin
            scl_nxt = 1'b0;
            done    = 1'b1;
          end else if (poll_inc > {1'b0, timeout_r}) begin
            // no acknowledge: run a stop and flag it at the end
            active_op_nxt = i2cmbs_pkg::OP_STOP_ERR;
            phase_nxt     = i2cmbs_pkg::PH_0;
            poll_nxt      = '0;
          end else begin
            poll_nxt = poll_inc[i2cmbs_pkg::POLL_W-1:0];
          end
        end
        i2cmbs_pkg::OP_READ: begin
          unique case (phase_r)
            i2cmbs_pkg::PH_0: begin
              sda_nxt   = 1'b1;
              drive_nxt = 1'b0;
              phase_nxt = i2cmbs_pkg::PH_1;
            end
            i2cmbs_pkg::PH_1: begin
              scl_nxt   = 1'b0;
              phase_nxt = i2cmbs_pkg::PH_2;
            end
            i2cmbs_pkg::PH_2: begin
              scl_nxt   = 1'b1;
              phase_nxt = i2cmbs_pkg::PH_3;
            end
            i2cmbs_pkg::PH_3: begin
              // sample SDA into the low bit
              shift_nxt   = {shift_r[i2cmbs_pkg::BYTE_W-2:0], in_sda_level};
              bit_cnt_nxt = bit_cnt_r + 1'b1;
              phase_nxt   = (bit_cnt_r >= i2cmbs_pkg::LAST_BIT) ?
                            i2cmbs_pkg::PH_4 : i2cmbs_pkg::PH_1;
            end
            default: begin
              scl_nxt = 1'b0;
              done    = 1'b1;
              rdata   = shift_r;
            end
          endcase
        end
        default: begin
          active_op_nxt = i2cmbs_pkg::OP_TICK;
          phase_nxt     = '0;
          bit_cnt_nxt   = '0;
        end
      endcase

      // drop back to idle once a sequence finishes
      if (done) begin
        active_op_nxt = i2cmbs_pkg::OP_TICK;
        phase_nxt     = '0;
        bit_cnt_nxt   = '0;
      end
    end

    res_nxt.scl       = scl_nxt;
    res_nxt.sda_out   = sda_nxt;
    res_nxt.sda_drive = drive_nxt;
    res_nxt.busy_res  = (active_op_nxt != i2cmbs_pkg::OP_TICK);
    res_nxt.done_res  = done;
    res_nxt.ack_error = err;
    res_nxt.read_data = rdata;
  end

  // Hold configuration and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= i2cmbs_pkg::TIMEOUT_RESET;
      active_op_r <= i2cmbs_pkg::OP_TICK;
      phase_r     <= '0;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      poll_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      drive_r     <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (in_xfer) begin
        active_op_r <= active_op_nxt;
        phase_r     <= phase_nxt;
        bit_cnt_r   <= bit_cnt_nxt;
        shift_r     <= shift_nxt;
        poll_r      <= poll_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        drive_r     <= drive_nxt;
      end
    end
  end

  // Advance the output register and skid buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!out_vld_r || out_xfer) begin
        if (skid_vld_r) begin
          out_vld_r  <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r <= in_xfer;
        end
      end
      if (in_xfer && out_vld_r && !(out_xfer && !skid_vld_r)) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  // Move payloads alongside the valid flags
  always_ff @(posedge clk) begin
    if (!out_vld_r || out_xfer) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else begin
        out_r <= res_nxt;
      end
    end
    if (in_xfer && out_vld_r && !(out_xfer && !skid_vld_r)) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_scl       = out_r.scl;
  assign out_sda_out   = out_r.sda_out;
  assign out_sda_drive = out_r.sda_drive;
  assign out_busy_res  = out_r.busy_res;
  assign out_done_res  = out_r.done_res;
  assign out_ack_error = out_r.ack_error;
  assign out_read_data = out_r.read_data;

endmodule

`default_nettype wire
